>>> hdl/ovft_pkg.sv
// ----------------------------------------------------------------------------
// ovft_pkg
// Shared types, constants and the arctangent step table for the orbit
// vector-field track unit.
// ----------------------------------------------------------------------------
package ovft_pkg;

	// datapath widths
	localparam int CW            = 56;   // CORDIC x/y width
	localparam int ZW            = 34;   // binary angle width (2^32 per turn)
	localparam int DW            = 35;   // distance width, Q.8 metres
	localparam int QDEPTH        = 4;    // front-to-back sample queue
	localparam int ODEPTH        = 2;    // result queue
	localparam int STEPS_DEFAULT = 16;
	localparam int STEPS_MAX     = 32;
	localparam int NORM_MSB      = 40;   // normalize until a magnitude reaches 2^40
	localparam int NGRP          = NORM_MSB / 8;

	localparam logic [19:0]          INVK_Q20     = 20'd636751;
	localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [ZW-1:0] HALF_TURN    = 34'sd2147483648;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_RADIUS   = 3'd2,
		REG_TURN     = 3'd3,
		REG_GAIN     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic [30:0]        radius;
		logic               turn_sense;
		logic [15:0]        gain;
	} orbit_cfg_t;

	// classified sample handed from front to back
	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic               on_axis;
	} sample_t;

	// atan(2^-i) in binary angle units
	function automatic logic [31:0] atan_step(input int unsigned i);
		case (i)
			0:  return 32'h20000000;
			1:  return 32'h12E4051E;
			2:  return 32'h09FB385B;
			3:  return 32'h051111D4;
			4:  return 32'h028B0D43;
			5:  return 32'h0145D7E1;
			6:  return 32'h00A2F61E;
			7:  return 32'h00517C55;
			8:  return 32'h0028BE53;
			9:  return 32'h00145F2F;
			10: return 32'h000A2F98;
			11: return 32'h000517CC;
			12: return 32'h00028BE6;
			13: return 32'h000145F3;
			14: return 32'h0000A2FA;
			15: return 32'h0000517D;
			16: return 32'h000028BE;
			17: return 32'h0000145F;
			18: return 32'h00000A30;
			19: return 32'h00000518;
			20: return 32'h0000028C;
			21: return 32'h00000146;
			22: return 32'h000000A3;
			23: return 32'h00000051;
			24: return 32'h00000029;
			25: return 32'h00000014;
			26: return 32'h0000000A;
			27: return 32'h00000005;
			28: return 32'h00000003;
			29: return 32'h00000001;
			30: return 32'h00000001;
			default: return 32'h00000000;
		endcase
	endfunction

endpackage

>>> hdl/ovft_front.sv
// ----------------------------------------------------------------------------
// ovft_front
// Takes position samples, forms the offset from the orbit centre, flags
// samples on the x axis and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module ovft_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  ovft_pkg::orbit_cfg_t cfg,
	output logic                q_valid,
	output ovft_pkg::sample_t   q_data,
	input  logic                q_pop
);
	import ovft_pkg::*;

	localparam int AW = $clog2(QDEPTH);

	sample_t        mem_q [QDEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;
	sample_t        in_item;
	logic           wr_en, rd_en;

	// offset from centre and axis flag
	always_comb begin
		in_item.dx      = $signed({pos_x[31], pos_x}) - $signed({cfg.center_x[31], cfg.center_x});
		in_item.dy      = $signed({pos_y[31], pos_y}) - $signed({cfg.center_y[31], cfg.center_y});
		in_item.on_axis = (in_item.dy == '0);
	end

	assign full    = (cnt_q == QDEPTH[AW:0]);
	assign q_valid = (cnt_q != '0);
	assign wr_en   = push && !full;
	assign rd_en   = q_pop && q_valid;
	assign q_data  = mem_q[rd_q];

	// store on transfer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= in_item;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wr_q <= wr_q + 1'b1;
			if (rd_en) rd_q <= rd_q + 1'b1;
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hdl/ovft_cordic.sv
// ----------------------------------------------------------------------------
// ovft_cordic
// Pipelined vectoring CORDIC: one prerotation stage and one stage per
// iteration. Returns the final x and the binary angle of the input vector.
// ----------------------------------------------------------------------------
module ovft_cordic #(
	parameter int STEPS = ovft_pkg::STEPS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic signed [ovft_pkg::CW-1:0]  x_in,
	input  logic signed [ovft_pkg::CW-1:0]  y_in,
	input  logic                            ax_in,
	output logic                            out_valid,
	output logic signed [ovft_pkg::CW-1:0]  x_out,
	output logic signed [ovft_pkg::ZW-1:0]  z_out
);
	import ovft_pkg::*;

	localparam int NS = (STEPS > STEPS_MAX) ? STEPS_MAX : STEPS;

	logic signed [CW-1:0] x_s [NS+1];
	logic signed [CW-1:0] y_s [NS+1];
	logic signed [ZW-1:0] z_s [NS+1];
	logic [NS:0]          v_s;
	logic [NS:0]          ax_s;
	logic [NS:0]          ng_s;

	// prerotate left half-plane vectors by a quarter turn
	always_ff @(posedge clk) begin
		if (en) begin
			if (x_in[CW-1]) begin
				if (!y_in[CW-1]) begin
					x_s[0] <= y_in;
					y_s[0] <= -x_in;
					z_s[0] <= QUARTER_TURN;
				end else begin
					x_s[0] <= -y_in;
					y_s[0] <= x_in;
					z_s[0] <= -QUARTER_TURN;
				end
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
			ax_s[0] <= ax_in;
			ng_s[0] <= x_in[CW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < NS; i++) begin : g_step
		localparam logic signed [ZW-1:0] ATAN_I = ZW'(atan_step(i));

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_I;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_I;
				end
				ax_s[i+1] <= ax_s[i];
				ng_s[i+1] <= ng_s[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
	end

	// exact angle for vectors on the x axis
	assign out_valid = v_s[NS];
	assign x_out     = x_s[NS];
	assign z_out     = ax_s[NS] ? (ng_s[NS] ? HALF_TURN : '0) : z_s[NS];

endmodule

>>> hdl/ovft_back.sv
// ----------------------------------------------------------------------------
// ovft_back
// Guidance pipeline: bearing and distance CORDIC, distance scaling, radial
// error, normalization, error-angle CORDIC, track conversion and the
// result queue.
// ----------------------------------------------------------------------------
module ovft_back #(
	parameter int STEPS = ovft_pkg::STEPS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ovft_pkg::orbit_cfg_t cfg,
	input  logic                 q_valid,
	input  ovft_pkg::sample_t    q_data,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [8:0]           track_deg
);
	import ovft_pkg::*;

	localparam int NS = (STEPS > STEPS_MAX) ? STEPS_MAX : STEPS;
	localparam int OW = $clog2(ODEPTH);

	function automatic logic [2:0] msb8(input logic [7:0] b);
		logic [2:0] m;
		m = '0;
		for (int j = 0; j < 8; j++) begin
			if (b[j]) m = 3'(j);
		end
		return m;
	endfunction

	logic                 en;
	logic                 o_full, o_push, o_pop;

	logic signed [CW-1:0] c1_x, c1_y, c1_xk;
	logic                 c1_v;
	logic signed [ZW-1:0] c1_z;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [43:0]          pplo_s1;
	logic [37:0]          pphi_s1;
	logic signed [ZW-1:0] bear_s1, bear_s2, bear_s3, bear_s4, bear_s5, bear_s6;
	logic [DW-1:0]        dist_s2;
	logic signed [53:0]   ey_s3, ey_s4, ey_s5;
	logic [38:0]          ex_s3, ex_s4, ex_s5;
	logic                 big_s4, zero_s4;
	logic [NGRP-1:0]      nz_s4;
	logic [2:0]           ms_s4 [NGRP];
	logic [5:0]           k_s5;
	logic signed [CW-1:0] x_s6, y_s6;
	logic                 ax_s6;
	logic signed [ZW-1:0] bear_dl [NS+1];

	logic                 c2_v;
	logic signed [CW-1:0] c2_x;
	logic signed [ZW-1:0] c2_z;

	logic [43:0]          prod_s7;
	logic                 neg_s7;
	logic [8:0]           trk_s8;

	logic [8:0]           ofifo_q [ODEPTH];
	logic [OW-1:0]        owr_q, ord_q;
	logic [OW:0]          ocnt_q;

	logic [CW-1:0]        xkc;
	logic [41:0]          xs;
	logic [62:0]          msum;
	logic signed [36:0]   err;
	logic [53:0]          mag_e, orm;
	logic [5:0]           p;
	logic signed [35:0]   t, v;
	logic [35:0]          vmag;
	logic [44:0]          rsum;
	logic [12:0]          r;

	// stall the whole pipeline only when a finished result cannot leave
	assign o_full = (ocnt_q == ODEPTH[OW:0]);
	assign o_push = v_s8 && !o_full;
	assign en     = !(v_s8 && o_full);
	assign q_pop  = en && q_valid;

	assign c1_x = {{(CW-49){q_data.dx[32]}}, q_data.dx, 16'b0};
	assign c1_y = {{(CW-49){q_data.dy[32]}}, q_data.dy, 16'b0};

	ovft_cordic #(.STEPS(STEPS)) u_bear (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (q_valid),
		.x_in      (c1_x),
		.y_in      (c1_y),
		.ax_in     (q_data.on_axis),
		.out_valid (c1_v),
		.x_out     (c1_xk),
		.z_out     (c1_z)
	);

	// datapath combinational terms
	always_comb begin
		xkc   = c1_xk[CW-1] ? '0 : c1_xk;
		xs    = xkc[49:8];
		msum  = 63'(pplo_s1) + (63'(pphi_s1) << 24) + 63'(64'd1 << 27);
		err   = $signed({2'b0, dist_s2}) - $signed({6'b0, cfg.radius});
		mag_e = ey_s3[53] ? 54'(-ey_s3) : 54'(ey_s3);
		orm   = mag_e | 54'(ex_s3);
		p     = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (nz_s4[g]) p = 6'(8 * g) + 6'(ms_s4[g]);
		end
		t = 36'(QUARTER_TURN) + 36'(c2_z);
		if (cfg.turn_sense) begin
			v = 36'(QUARTER_TURN) - (36'(bear_dl[NS]) - t);
		end else begin
			v = 36'(QUARTER_TURN) - (36'(bear_dl[NS]) + t);
		end
		vmag = v[35] ? 36'(-v) : 36'(v);
		rsum = 45'(prod_s7) + 45'(64'd1 << 31);
		r    = rsum[44:32];
		for (int j = 0; j < 4; j++) begin
			if (r >= 13'd360) r = r - 13'd360;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			pplo_s1 <= 44'(xs[23:0]) * 44'(INVK_Q20);
			pphi_s1 <= 38'(xs[41:24]) * 38'(INVK_Q20);
			bear_s1 <= c1_z;

			dist_s2 <= msum[62:28];
			bear_s2 <= bear_s1;

			ey_s3   <= $signed({1'b0, cfg.gain}) * err;
			ex_s3   <= {cfg.radius, 8'b0};
			bear_s3 <= bear_s2;

			big_s4  <= |orm[53:NORM_MSB];
			zero_s4 <= (orm == '0);
			for (int g = 0; g < NGRP; g++) begin
				nz_s4[g] <= |orm[8*g +: 8];
				ms_s4[g] <= msb8(orm[8*g +: 8]);
			end
			ex_s4   <= ex_s3;
			ey_s4   <= ey_s3;
			bear_s4 <= bear_s3;

			k_s5    <= (big_s4 || zero_s4) ? '0 : 6'(NORM_MSB) - p;
			ex_s5   <= ex_s4;
			ey_s5   <= ey_s4;
			bear_s5 <= bear_s4;

			x_s6    <= CW'(ex_s5) << k_s5;
			y_s6    <= CW'(ey_s5) <<< k_s5;
			ax_s6   <= (ey_s5 == '0);
			bear_s6 <= bear_s5;

			bear_dl[0] <= bear_s6;
			for (int i = 0; i < NS; i++) begin
				bear_dl[i+1] <= bear_dl[i];
			end

			prod_s7 <= vmag[34:0] * 44'd360;
			neg_s7  <= v[35];

			trk_s8  <= (neg_s7 && r != '0) ? 9'(13'd360 - r) : 9'(r);
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= c1_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= c2_v;
			v_s8 <= v_s7;
		end
	end

	ovft_cordic #(.STEPS(STEPS)) u_err (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.x_in      (x_s6),
		.y_in      (y_s6),
		.ax_in     (ax_s6),
		.out_valid (c2_v),
		.x_out     (c2_x),
		.z_out     (c2_z)
	);

	// result queue
	assign empty     = (ocnt_q == '0);
	assign o_pop     = pop && !empty;
	assign track_deg = ofifo_q[ord_q];

	always_ff @(posedge clk) begin
		if (o_push) begin
			ofifo_q[owr_q] <= trk_s8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (o_push) owr_q <= owr_q + 1'b1;
			if (o_pop)  ord_q <= ord_q + 1'b1;
			case ({o_push, o_pop})
				2'b10:   ocnt_q <= ocnt_q + 1'b1;
				2'b01:   ocnt_q <= ocnt_q - 1'b1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	// final x of the error-angle CORDIC carries no information downstream
	logic unused_c2x;
	assign unused_c2x = ^c2_x;

endmodule

>>> hdl/orbit_vector_field_track_unit.sv
// ----------------------------------------------------------------------------
// orbit_vector_field_track_unit
// Orbit-following vector-field guidance: position sample in, commanded
// track in whole degrees out.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive pos_x/pos_y with push; a transfer happens
//   when push is high and full is low. Result side is a queue: track_deg is
//   valid while empty is low and is taken with pop.
//   Configuration is a plain write port (cfg_we, cfg_idx, cfg_wdata):
//   0 center_x, 1 center_y, 2 orbit_radius, 3 turn_sense, 4 orbit_gain.
//   Write it only while no sample is in flight.
//   Throughput: one sample per cycle unless a full result queue stalls
//   the pipeline. The path from transfer in to result visible runs
//   through two pipelined CORDICs (one stage per iteration plus prerotation).
//   Reset empties both queues and all stage valids and loads the register
//   defaults (centre 0, radius 50 m, positive turn, gain 1.0).
//   When pop stays low, the two-entry result queue fills, the pipeline
//   holds in place, the four-entry input queue fills and full rises.
// ----------------------------------------------------------------------------
module orbit_vector_field_track_unit #(
	parameter int CORDIC_STEPS = ovft_pkg::STEPS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	output logic               empty,
	input  logic               pop,
	output logic [8:0]         track_deg
);
	import ovft_pkg::*;

	orbit_cfg_t cfg_q;
	logic       q_valid, q_pop;
	sample_t    q_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x   <= '0;
			cfg_q.center_y   <= '0;
			cfg_q.radius     <= 31'd12800;
			cfg_q.turn_sense <= 1'b0;
			cfg_q.gain       <= 16'd256;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_CENTER_X: cfg_q.center_x   <= $signed(cfg_wdata);
				REG_CENTER_Y: cfg_q.center_y   <= $signed(cfg_wdata);
				REG_RADIUS:   cfg_q.radius     <= cfg_wdata[30:0];
				REG_TURN:     cfg_q.turn_sense <= cfg_wdata[0];
				REG_GAIN:     cfg_q.gain       <= cfg_wdata[15:0];
				default:      cfg_q            <= cfg_q;
			endcase
		end
	end

	ovft_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.pos_x   (pos_x),
		.pos_y   (pos_y),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop)
	);

	ovft_back #(.STEPS(CORDIC_STEPS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.track_deg (track_deg)
	);

	// a full input queue always offers a sample to the back end
	a_full_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_valid) else $error("input queue full but no sample offered");

	// a transfer into an empty input queue is offered next cycle
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !q_valid) |=> q_valid) else $error("accepted sample lost");

	// the back end only drains samples that exist
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("drain from empty input queue");

	// results are wrapped whole degrees
	a_track_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (track_deg < 9'd360)) else $error("track out of range");

endmodule
